>>> sv/scps_pkg.sv
// shared types, constants and helpers for the servo chain pulse sequencer
// no dependencies
`timescale 1ns / 1ps

package scps_pkg;

   localparam int CHAN_W  = 3;
   localparam int WIDTH_W = 16;
   localparam int ACT_W   = 2;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int ARITH_W = 20;

   typedef logic signed [ARITH_W-1:0] arith_type;

   // request operation codes
   localparam logic OP_TIMER = 1'b0;
   localparam logic OP_SET   = 1'b1;

   // pin action codes
   localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_HIGH = 2'd1;
   localparam logic [ACT_W-1:0] ACT_LOW  = 2'd2;

   // register indexes, byte address is four times the index
   localparam logic [2:0] REG_MIN_WIDTH  = 3'd0;
   localparam logic [2:0] REG_MAX_WIDTH  = 3'd1;
   localparam logic [2:0] REG_SLOT_TIME  = 3'd2;
   localparam logic [2:0] REG_BOUND_MASK = 3'd3;
   localparam logic [2:0] REG_PULSES_ON  = 3'd4;
   localparam logic [2:0] REG_FINE_MODE  = 3'd5;

   localparam arith_type PULSE_CORR = 20'sd9;
   localparam arith_type MIN_TIMER  = 20'sd4;
   localparam arith_type SAT_MAX    = 20'sd65535;

   typedef struct packed {
      logic [WIDTH_W-1:0] min_width;
      logic [WIDTH_W-1:0] max_width;
      logic [WIDTH_W-1:0] slot_time;
      logic [7:0]         bound_mask;
      logic               pulses_on;
      logic               fine_mode;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic [CHAN_W-1:0]  addr;
      logic [WIDTH_W-1:0] data;
   } len_wr_type;

   function automatic logic [WIDTH_W-1:0] sat16(input arith_type v);
      logic [WIDTH_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > SAT_MAX) begin
         r = '1;
      end else begin
         r = v[WIDTH_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> sv/scps_csr.sv
// configuration register file with apb-style access
// depends on scps_pkg
`timescale 1ns / 1ps

module scps_csr
   import scps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_width  <= 16'd1000;
         cfg_ff.max_width  <= 16'd2000;
         cfg_ff.slot_time  <= 16'd2500;
         cfg_ff.bound_mask <= 8'd0;
         cfg_ff.pulses_on  <= 1'b0;
         cfg_ff.fine_mode  <= 1'b1;
      end else if (wr_en) begin
         case (reg_idx)
            REG_MIN_WIDTH:  cfg_ff.min_width  <= pwdata[WIDTH_W-1:0];
            REG_MAX_WIDTH:  cfg_ff.max_width  <= pwdata[WIDTH_W-1:0];
            REG_SLOT_TIME:  cfg_ff.slot_time  <= pwdata[WIDTH_W-1:0];
            REG_BOUND_MASK: cfg_ff.bound_mask <= pwdata[7:0];
            REG_PULSES_ON:  cfg_ff.pulses_on  <= pwdata[0];
            REG_FINE_MODE:  cfg_ff.fine_mode  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MIN_WIDTH:  prdata = DATA_W'(cfg_ff.min_width);
         REG_MAX_WIDTH:  prdata = DATA_W'(cfg_ff.max_width);
         REG_SLOT_TIME:  prdata = DATA_W'(cfg_ff.slot_time);
         REG_BOUND_MASK: prdata = DATA_W'(cfg_ff.bound_mask);
         REG_PULSES_ON:  prdata = DATA_W'(cfg_ff.pulses_on);
         REG_FINE_MODE:  prdata = DATA_W'(cfg_ff.fine_mode);
         default:        prdata = '0;
      endcase
   end

endmodule

>>> sv/scps_len_mem.sv
// pulse length memory, one entry per channel, registered read with write bypass
// depends on scps_pkg
`timescale 1ns / 1ps

module scps_len_mem
   import scps_pkg::*;
#(
   parameter int NUM_CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [CHAN_W-1:0]  rd_chan,
   input  len_wr_type         wr,
   output logic [WIDTH_W-1:0] rd_len
);

   localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int DEPTH = 1 << AW;

   logic [WIDTH_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   logic [WIDTH_W-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic               byp_ff;
   logic [WIDTH_W-1:0] byp_data_ff;

   // entries never written read back as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr[AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr[AW-1:0]] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_chan[AW-1:0]];
         rd_vld_ff   <= vld_ff[rd_chan[AW-1:0]];
         // write landing on the entry being read in the same cycle
         byp_ff      <= wr.en && (wr.addr[AW-1:0] == rd_chan[AW-1:0]);
         byp_data_ff <= wr.data;
      end
   end

   assign rd_len = byp_ff ? byp_data_ff : (rd_vld_ff ? rd_data_ff : '0);

endmodule

>>> sv/scps_seq.sv
// phase machine, request stage and result register of the pulse sequencer
// depends on scps_pkg; reads and writes the length memory through ports
`timescale 1ns / 1ps

module scps_seq
   import scps_pkg::*;
#(
   parameter int NUM_CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [CHAN_W-1:0]  req_chan_sel,
   input  logic [WIDTH_W-1:0] req_width_us,
   output logic               rd_en,
   output logic [CHAN_W-1:0]  rd_chan,
   input  logic [WIDTH_W-1:0] rd_len,
   output len_wr_type         wr,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ACT_W-1:0]   rsp_pin_action,
   output logic [CHAN_W-1:0]  rsp_pin_channel,
   output logic               rsp_load_valid,
   output logic [WIDTH_W-1:0] rsp_timer_load
);

   typedef enum logic [1:0] {
      PH_PULSE_BASE  = 2'd0,
      PH_PULSE_EXT   = 2'd1,
      PH_PULSE_PAUSE = 2'd2,
      PH_PAUSE_BASE  = 2'd3
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in, chan_adv;
   logic [WIDTH_W-1:0] pause_ff, pause_in;

   logic               s1_valid_ff;
   logic               s1_op_ff;
   logic [CHAN_W-1:0]  s1_sel_ff;
   logic [WIDTH_W-1:0] s1_w_ff;

   logic               rsp_valid_ff;
   logic [ACT_W-1:0]   act_ff, act_in;
   logic [CHAN_W-1:0]  pch_ff, pch_in;
   logic               lvld_ff, lvld_in;
   logic [WIDTH_W-1:0] load_ff, load_in;

   logic               s1_adv, accept, bound;
   logic [WIDTH_W-1:0] w_cl;
   arith_type          mn_s, len_s, slot_s, w_s;
   len_wr_type         wr_c;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   assign chan_adv = (chan_ff == CHAN_W'(NUM_CHANNELS - 1)) ? '0 : chan_ff + 3'd1;
   assign bound    = cfg.bound_mask[chan_ff];

   assign w_cl = (s1_w_ff < cfg.min_width) ? cfg.min_width :
                 ((s1_w_ff > cfg.max_width) ? cfg.max_width : s1_w_ff);

   assign mn_s   = ARITH_W'(cfg.min_width);
   assign len_s  = ARITH_W'(rd_len);
   assign slot_s = ARITH_W'(cfg.slot_time) - PULSE_CORR;
   assign w_s    = ARITH_W'(w_cl);

   // the next request reads the length of the channel that is active once
   // the request now in the stage has been retired
   assign rd_en   = accept;
   assign rd_chan = s1_adv ? chan_in : chan_ff;

   always_comb begin
      act_in   = ACT_NONE;
      pch_in   = '0;
      lvld_in  = 1'b0;
      load_in  = '0;
      phase_in = phase_ff;
      chan_in  = chan_ff;
      pause_in = pause_ff;
      wr_c     = '0;
      if (s1_op_ff == OP_SET) begin
         wr_c.en   = ({1'b0, s1_sel_ff} < (CHAN_W + 1)'(NUM_CHANNELS));
         wr_c.addr = s1_sel_ff;
         wr_c.data = cfg.fine_mode ? sat16((w_s - PULSE_CORR) <<< 1)
                                   : sat16((w_s - mn_s) >>> 2);
      end else begin
         lvld_in = 1'b1;
         if (cfg.fine_mode) begin
            if (phase_ff == PH_PULSE_PAUSE) begin
               if (bound) begin
                  act_in = ACT_LOW;
                  pch_in = chan_ff;
               end
               phase_in = PH_PULSE_BASE;
               chan_in  = chan_adv;
               load_in  = pause_ff;
            end else begin
               phase_in = PH_PULSE_PAUSE;
               if (bound) begin
                  if (cfg.pulses_on) begin
                     act_in = ACT_HIGH;
                     pch_in = chan_ff;
                  end
                  pause_in = sat16((slot_s <<< 1) - len_s);
                  load_in  = rd_len;
               end else begin
                  pause_in = sat16(slot_s);
                  load_in  = sat16(slot_s);
               end
            end
         end else begin
            case (phase_ff)
               PH_PULSE_BASE: begin
                  phase_in = PH_PULSE_EXT;
                  if (bound && cfg.pulses_on) begin
                     act_in = ACT_HIGH;
                     pch_in = chan_ff;
                  end
                  load_in = sat16(((mn_s - PULSE_CORR) >>> 2) - MIN_TIMER);
               end
               PH_PULSE_EXT: begin
                  phase_in = PH_PULSE_PAUSE;
                  if (bound) begin
                     pause_in = sat16((mn_s >>> 2) - len_s + MIN_TIMER);
                     load_in  = sat16(len_s + MIN_TIMER);
                  end else begin
                     pause_in = sat16((mn_s >>> 3) + MIN_TIMER);
                     load_in  = sat16((mn_s >>> 3) + MIN_TIMER);
                  end
               end
               PH_PULSE_PAUSE: begin
                  if (bound) begin
                     act_in = ACT_LOW;
                     pch_in = chan_ff;
                  end
                  phase_in = PH_PAUSE_BASE;
                  chan_in  = chan_adv;
                  load_in  = pause_ff;
               end
               default: begin
                  phase_in = PH_PULSE_BASE;
                  load_in  = sat16(((mn_s - (PULSE_CORR <<< 1)) >>> 3) - MIN_TIMER);
               end
            endcase
         end
      end
   end

   always_comb begin
      wr    = wr_c;
      wr.en = wr_c.en && s1_adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PULSE_BASE;
         chan_ff      <= '0;
         pause_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            phase_ff <= phase_in;
            chan_ff  <= chan_in;
            pause_ff <= pause_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         s1_op_ff  <= req_operation;
         s1_sel_ff <= req_chan_sel;
         s1_w_ff   <= req_width_us;
      end
      if (s1_adv) begin
         act_ff  <= act_in;
         pch_ff  <= pch_in;
         lvld_ff <= lvld_in;
         load_ff <= load_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pin_action  = act_ff;
   assign rsp_pin_channel = pch_ff;
   assign rsp_load_valid  = lvld_ff;
   assign rsp_timer_load  = load_ff;

endmodule

>>> sv/servo_chain_pulse_sequencer.sv
// top level of the servo chain pulse sequencer
// depends on scps_pkg, scps_csr, scps_len_mem and scps_seq
`timescale 1ns / 1ps

// Usage
// The req channel takes one request per cycle while req_stall is low:
// operation 1 (set value) stores a pulse length from the clamped width for
// req_chan_sel, operation 0 (timer expired) steps the phase machine of the
// active channel. Every request gives exactly one result on the rsp channel:
// pin action, its channel, and the next timer load. A request accepted at a
// clock edge sits in the request stage while the length memory read launched
// at that same edge completes; the result register then loads it and puts the
// result on the rsp ports. Throughput is one request per cycle, back to back,
// while rsp_stall is low; a set value writing the entry that the next request
// reads at the same edge is served by a bypass.
// While rsp_stall is high the result register holds and one more request waits
// in the read stage; req_stall rises only when both are full. Registers must
// be written through the apb port only while no request is in flight; the block
// does not enforce it. Reset (synchronous) restores register defaults, returns
// the phase machine to pulse base on channel 0, clears the pause length and
// marks every stored pulse length as zero at once; no clearing pass is needed.

module servo_chain_pulse_sequencer
   import scps_pkg::*;
#(
   parameter int NUM_CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [CHAN_W-1:0]  req_chan_sel,
   input  logic [WIDTH_W-1:0] req_width_us,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ACT_W-1:0]   rsp_pin_action,
   output logic [CHAN_W-1:0]  rsp_pin_channel,
   output logic               rsp_load_valid,
   output logic [WIDTH_W-1:0] rsp_timer_load
);

   cfg_type            cfg;
   logic               rd_en;
   logic [CHAN_W-1:0]  rd_chan;
   logic [WIDTH_W-1:0] rd_len;
   len_wr_type         wr;

   scps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   scps_len_mem #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_len_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_chan (rd_chan),
      .wr      (wr),
      .rd_len  (rd_len)
   );

   scps_seq #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_chan_sel    (req_chan_sel),
      .req_width_us    (req_width_us),
      .rd_en           (rd_en),
      .rd_chan         (rd_chan),
      .rd_len          (rd_len),
      .wr              (wr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pin_action  (rsp_pin_action),
      .rsp_pin_channel (rsp_pin_channel),
      .rsp_load_valid  (rsp_load_valid),
      .rsp_timer_load  (rsp_timer_load)
   );

endmodule

>>> sv/scps_checker.sv
// port-level checks for the servo chain pulse sequencer, bound to the top level
// depends on scps_pkg and servo_chain_pulse_sequencer
`timescale 1ns / 1ps

module scps_checker
   import scps_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [ACT_W-1:0]   rsp_pin_action,
   input logic [CHAN_W-1:0]  rsp_pin_channel,
   input logic               rsp_load_valid,
   input logic [WIDTH_W-1:0] rsp_timer_load
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pin_action)
         && $stable(rsp_pin_channel) && $stable(rsp_load_valid)
         && $stable(rsp_timer_load))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // set value results are all zero
   a_set_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_load_valid |-> rsp_pin_action == ACT_NONE
         && rsp_timer_load == '0)
      else $error("set value result not zero");

   a_idle_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pin_action == ACT_NONE |-> rsp_pin_channel == '0)
      else $error("pin channel set without pin action");

   // with the result register empty an accepted request comes out right after the request stage
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> ##1 rsp_valid)
      else $error("result missing after accepted request");

endmodule

bind servo_chain_pulse_sequencer scps_checker u_scps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pin_action  (rsp_pin_action),
   .rsp_pin_channel (rsp_pin_channel),
   .rsp_load_valid  (rsp_load_valid),
   .rsp_timer_load  (rsp_timer_load)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// testbench for the servo chain pulse sequencer: directed and random requests, with each
// result checked against an in-bench model of the slot phase machine; needs scps_pkg and the rtl

module testbench
   import scps_pkg::*;
();

   localparam int NUM_CH        = 8;
   localparam int PULSE_CORR_US = 9;
   localparam int MIN_TICKS     = 4;
   localparam int HOLD_CYCLES   = 80;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 150;

   typedef enum logic [1:0] {
      PH_PULSE_BASE  = 2'd0,
      PH_PULSE_EXT   = 2'd1,
      PH_PULSE_PAUSE = 2'd2,
      PH_PAUSE_BASE  = 2'd3
   } seq_phase_type;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [CHAN_W-1:0]  channel;
      logic               load_valid;
      logic [WIDTH_W-1:0] load;
   } pin_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [ADDR_W-1:0]  paddr = '0;
   logic [DATA_W-1:0]  pwdata = '0;
   logic [DATA_W-1:0]  prdata;
   logic               pready;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = OP_TIMER;
   logic [CHAN_W-1:0]  req_chan_sel = '0;
   logic [WIDTH_W-1:0] req_width_us = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [ACT_W-1:0]   rsp_pin_action;
   logic [CHAN_W-1:0]  rsp_pin_channel;
   logic               rsp_load_valid;
   logic [WIDTH_W-1:0] rsp_timer_load;

   // model state
   cfg_type            cfg_shadow;
   seq_phase_type      seq_phase;
   logic [CHAN_W-1:0]  cur_chan;
   logic [WIDTH_W-1:0] pause_len;
   logic [WIDTH_W-1:0] pulse_len [NUM_CH];

   pin_result_type     pin_expect_q [$];
   pin_result_type     pin_head;
   int                 error_count = 0;
   logic               quiet_stretch = 1'b0;
   logic               hold_request = 1'b0;

   servo_chain_pulse_sequencer #(
      .NUM_CHANNELS(NUM_CH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_chan_sel(req_chan_sel),
      .req_width_us(req_width_us),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pin_action(rsp_pin_action),
      .rsp_pin_channel(rsp_pin_channel),
      .rsp_load_valid(rsp_load_valid),
      .rsp_timer_load(rsp_timer_load)
   );

   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [WIDTH_W-1:0] clip16(input int v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return WIDTH_W'(v);
   endfunction

   function automatic void reset_model();
      cfg_shadow.min_width  = 16'd1000;
      cfg_shadow.max_width  = 16'd2000;
      cfg_shadow.slot_time  = 16'd2500;
      cfg_shadow.bound_mask = 8'h00;
      cfg_shadow.pulses_on  = 1'b0;
      cfg_shadow.fine_mode  = 1'b1;
      seq_phase = PH_PULSE_BASE;
      cur_chan  = '0;
      pause_len = '0;
      for (int i = 0; i < NUM_CH; i++) pulse_len[i] = '0;
   endfunction

   function automatic void next_chan();
      if (int'(cur_chan) + 1 >= NUM_CH) cur_chan = '0;
      else cur_chan = cur_chan + 1'b1;
   endfunction

   // one request through the phase machine, returns the expected result
   function automatic pin_result_type predict_pulse(input logic op,
                                                    input logic [CHAN_W-1:0] sel,
                                                    input logic [WIDTH_W-1:0] width);
      pin_result_type r;
      int w, mn, mx, len, slot;
      logic bound;
      logic [CHAN_W-1:0] ch;
      r = '0;
      mn = int'(cfg_shadow.min_width);
      mx = int'(cfg_shadow.max_width);
      ch = cur_chan;
      if (op == OP_SET) begin
         if (int'(sel) < NUM_CH) begin
            // floor first; crossed limits give min_width below it, else max_width
            w = int'(width);
            if (w < mn) w = mn;
            else if (w > mx) w = mx;
            if (cfg_shadow.fine_mode) pulse_len[sel] = clip16(2 * (w - PULSE_CORR_US));
            else pulse_len[sel] = clip16((w - mn) / 4);
         end
         return r;
      end
      bound = (int'(ch) < NUM_CH) && cfg_shadow.bound_mask[ch];
      len = int'(pulse_len[ch]);
      slot = int'(cfg_shadow.slot_time) - PULSE_CORR_US;
      r.load_valid = 1'b1;
      if (cfg_shadow.fine_mode) begin
         if (seq_phase == PH_PULSE_PAUSE) begin
            if (bound) begin
               r.action = ACT_LOW;
               r.channel = ch;
            end
            seq_phase = PH_PULSE_BASE;
            next_chan();
            r.load = pause_len;
         end else begin
            // extension and pause base behave as pulse base here
            seq_phase = PH_PULSE_PAUSE;
            if (bound) begin
               if (cfg_shadow.pulses_on) begin
                  r.action = ACT_HIGH;
                  r.channel = ch;
               end
               pause_len = clip16(2 * slot - len);
               r.load = WIDTH_W'(len);
            end else begin
               pause_len = clip16(slot);
               r.load = clip16(slot);
            end
         end
      end else begin
         case (seq_phase)
            PH_PULSE_BASE: begin
               seq_phase = PH_PULSE_EXT;
               if (bound && cfg_shadow.pulses_on) begin
                  r.action = ACT_HIGH;
                  r.channel = ch;
               end
               r.load = clip16((mn - PULSE_CORR_US) / 4 - MIN_TICKS);
            end
            PH_PULSE_EXT: begin
               seq_phase = PH_PULSE_PAUSE;
               if (bound) begin
                  pause_len = clip16(mn / 4 - len + MIN_TICKS);
                  r.load = clip16(len + MIN_TICKS);
               end else begin
                  pause_len = clip16(mn / 8 + MIN_TICKS);
                  r.load = clip16(mn / 8 + MIN_TICKS);
               end
            end
            PH_PULSE_PAUSE: begin
               if (bound) begin
                  r.action = ACT_LOW;
                  r.channel = ch;
               end
               seq_phase = PH_PAUSE_BASE;
               next_chan();
               r.load = pause_len;
            end
            default: begin
               seq_phase = PH_PULSE_BASE;
               r.load = clip16((mn - 2 * PULSE_CORR_US) / 8 - MIN_TICKS);
            end
         endcase
      end
      return r;
   endfunction

   // picks a 16-bit register setting, extremes now and then
   function automatic logic [WIDTH_W-1:0] pick_setting(input int lo, input int hi);
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return WIDTH_W'($urandom);
         default: return WIDTH_W'($urandom_range(hi, lo));
      endcase
   endfunction

   task automatic report_mismatch(input string field, input int expected, input int actual);
      $display("%0t mismatch %s expected %0d actual %0d", $time, field, expected, actual);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pin_expect_q.size() == 0) begin
            $display("%0t unexpected result expected none actual action %0d load %0d",
                     $time, rsp_pin_action, rsp_timer_load);
            error_count++;
         end else begin
            pin_head = pin_expect_q.pop_front();
            if (rsp_pin_action !== pin_head.action)
               report_mismatch("pin_action", pin_head.action, rsp_pin_action);
            if (rsp_pin_channel !== pin_head.channel)
               report_mismatch("pin_channel", pin_head.channel, rsp_pin_channel);
            if (rsp_load_valid !== pin_head.load_valid)
               report_mismatch("load_valid", pin_head.load_valid, rsp_load_valid);
            if (rsp_timer_load !== pin_head.load)
               report_mismatch("timer_load", pin_head.load, rsp_timer_load);
         end
      end
   end

   // result side: random stalls, or a long hold-off when asked
   initial begin
      int hold_left;
      logic holding;
      logic quiet_now;
      hold_left = 0;
      holding = 1'b0;
      forever begin
         @(posedge clock);
         quiet_now = quiet_stretch;
         if (hold_request) begin
            if (!holding) begin
               holding = 1'b1;
               hold_left = HOLD_CYCLES;
            end else if (hold_left == 0) begin
               holding = 1'b0;
               hold_request = 1'b0;
            end
         end
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !quiet_now && ($urandom_range(99) < 9);
         end
      end
   end

   task automatic csr_write(input int idx, input logic [WIDTH_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * idx);
      pwdata  <= DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_MIN_WIDTH:  cfg_shadow.min_width  = value;
         REG_MAX_WIDTH:  cfg_shadow.max_width  = value;
         REG_SLOT_TIME:  cfg_shadow.slot_time  = value;
         REG_BOUND_MASK: cfg_shadow.bound_mask = value[7:0];
         REG_PULSES_ON:  cfg_shadow.pulses_on  = value[0];
         REG_FINE_MODE:  cfg_shadow.fine_mode  = value[0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic op, input logic [CHAN_W-1:0] ch,
                               input logic [WIDTH_W-1:0] w);
      int gap;
      if (!quiet_stretch && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         gap = $urandom_range(3, 1);
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_chan_sel  <= ch;
      req_width_us  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pin_expect_q.push_back(predict_pulse(op, ch, w));
      @(negedge clock);
   endtask

   task automatic send_random_request();
      logic op;
      int mn, mx, lo, hi;
      logic [WIDTH_W-1:0] w;
      op = ($urandom_range(99) < 35) ? OP_SET : OP_TIMER;
      mn = int'(cfg_shadow.min_width);
      mx = int'(cfg_shadow.max_width);
      lo = ((mn < mx) ? mn : mx) - 300;
      hi = ((mn > mx) ? mn : mx) + 300;
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      case ($urandom_range(7))
         0, 1: w = WIDTH_W'($urandom);
         2: w = cfg_shadow.min_width;
         3: w = cfg_shadow.max_width;
         default: w = WIDTH_W'($urandom_range(hi, lo));
      endcase
      send_request(op, CHAN_W'($urandom), w);
   endtask

   // sender pauses until every request has its result
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pin_expect_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic test_default_slots();
      repeat (3) send_request(OP_TIMER, '0, '0);
      send_request(OP_SET, 3'd0, 16'd0);
      send_request(OP_SET, 3'd7, 16'hFFFF);
   endtask

   task automatic test_fine_pulses();
      wait_drained();
      csr_write(REG_BOUND_MASK, 16'h00FF);
      csr_write(REG_PULSES_ON, 16'd1);
      send_request(OP_SET, 3'd1, 16'd1500);
      repeat (4) send_request(OP_TIMER, 3'd7, 16'hFFFF);
   endtask

   // bound pins still go low at their pause with pulses off
   task automatic test_stop_without_enable();
      wait_drained();
      csr_write(REG_PULSES_ON, 16'd0);
      repeat (2) send_request(OP_TIMER, '0, '0);
   endtask

   // lengths stored in fine units are kept across the switch
   task automatic test_coarse_phases();
      wait_drained();
      csr_write(REG_PULSES_ON, 16'd1);
      csr_write(REG_FINE_MODE, 16'd0);
      repeat (5) send_request(OP_TIMER, '0, '0);
      send_request(OP_SET, 3'd2, 16'd1800);
   endtask

   task automatic test_crossed_limits();
      wait_drained();
      csr_write(REG_MIN_WIDTH, 16'd3000);
      csr_write(REG_MAX_WIDTH, 16'd500);
      send_request(OP_SET, 3'd3, 16'd2999);
      send_request(OP_SET, 3'd4, 16'd3000);
      send_request(OP_SET, 3'd5, 16'd100);
   endtask

   // negative loads and pauses clip to zero
   task automatic test_saturation();
      wait_drained();
      csr_write(REG_MIN_WIDTH, 16'd0);
      csr_write(REG_SLOT_TIME, 16'd0);
      csr_write(REG_FINE_MODE, 16'd1);
      repeat (2) send_request(OP_TIMER, '0, '0);
      wait_drained();
      csr_write(REG_FINE_MODE, 16'd0);
      repeat (2) send_request(OP_TIMER, '0, '0);
   endtask

   // long receiver hold-off while requests keep coming, then a full drain
   task automatic test_backpressure();
      wait_drained();
      csr_write(REG_MIN_WIDTH, 16'd1000);
      csr_write(REG_MAX_WIDTH, 16'd2000);
      csr_write(REG_SLOT_TIME, 16'd2500);
      hold_request = 1'b1;
      repeat (40) send_random_request();
      while (hold_request) @(negedge clock);
      wait_drained();
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         quiet_stretch = (p == 5);
         if (p == 0) begin
            csr_write(REG_MIN_WIDTH, 16'd0);
            csr_write(REG_MAX_WIDTH, 16'hFFFF);
            csr_write(REG_SLOT_TIME, 16'hFFFF);
         end else if (p == 1) begin
            csr_write(REG_MIN_WIDTH, 16'hFFFF);
            csr_write(REG_MAX_WIDTH, 16'd0);
            csr_write(REG_SLOT_TIME, 16'd0);
         end else begin
            csr_write(REG_MIN_WIDTH, pick_setting(400, 1500));
            csr_write(REG_MAX_WIDTH, pick_setting(1500, 2500));
            csr_write(REG_SLOT_TIME, pick_setting(2000, 3000));
         end
         case ($urandom_range(3))
            0: csr_write(REG_BOUND_MASK, 16'h0000);
            1: csr_write(REG_BOUND_MASK, 16'h00FF);
            default: csr_write(REG_BOUND_MASK, 16'($urandom_range(255)));
         endcase
         csr_write(REG_PULSES_ON, 16'($urandom_range(1)));
         csr_write(REG_FINE_MODE, 16'($urandom_range(1)));
         repeat (PHASE_ITEMS) send_random_request();
      end
      quiet_stretch = 1'b0;
   endtask

   initial begin
      reset_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_slots();
      test_fine_pulses();
      test_stop_without_enable();
      test_coarse_phases();
      test_crossed_limits();
      test_saturation();
      test_backpressure();
      test_random_settings();
      wait_drained();
      repeat (10) @(posedge clock);
      if (pin_expect_q.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
